>>> sv/asgr_pkg.sv
// ----------------------------------------------------------------------------
// ANSI SGR text attribute parser package
// Shared types, byte codes and SGR decode for the log-line attribute parser.
// ----------------------------------------------------------------------------
package asgr_pkg;

    localparam int MAX_PARAMS = 16;
    localparam int PCOUNT_W   = $clog2(MAX_PARAMS + 1);

    localparam logic [9:0] PARAM_SAT = 10'd1023;
    localparam logic [9:0] COL_RESET = 10'd80;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] CSI_BYTE   = 8'h5B;
    localparam logic [7:0] SEMI_BYTE  = 8'h3B;
    localparam logic [7:0] TAB_BYTE   = 8'h09;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] FINAL_MIN  = 8'h40;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [9:0] SGR_RESET        = 10'd0;
    localparam logic [9:0] SGR_BOLD         = 10'd1;
    localparam logic [9:0] SGR_DIM          = 10'd2;
    localparam logic [9:0] SGR_UNDERLINE    = 10'd4;
    localparam logic [9:0] SGR_NORMAL_INT   = 10'd22;
    localparam logic [9:0] SGR_FG_FIRST     = 10'd30;
    localparam logic [9:0] SGR_FG_LAST      = 10'd37;
    localparam logic [9:0] SGR_FG_BASE      = 10'd39;
    localparam logic [9:0] SGR_BRIGHT_FIRST = 10'd90;
    localparam logic [9:0] SGR_BRIGHT_LAST  = 10'd97;

    localparam logic [3:0] COLOUR_ANSI_BASE = 4'd2;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_SGR    = 3'b100
    } mode_t;

    typedef struct packed {
        logic       bold;
        logic       dim;
        logic       underline;
        logic [3:0] colour;
    } attr_t;

    typedef struct packed {
        logic [7:0] data;
        logic       line_start;
        logic       error_line;
    } item_t;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  length;
        logic [9:0]  column;
        attr_t       attr;
    } glyph_t;

    function automatic attr_t plain_line_attr(input logic err);
        attr_t a;
        a.bold      = 1'b0;
        a.dim       = 1'b0;
        a.underline = 1'b0;
        a.colour    = {3'b000, err};
        return a;
    endfunction

    function automatic attr_t apply_code(input attr_t a, input logic err,
                                         input logic [9:0] code);
        attr_t r;
        r = a;
        unique case (code) inside
            SGR_RESET:      r = plain_line_attr(err);
            SGR_BOLD:       r.bold = 1'b1;
            SGR_DIM:        r.dim = 1'b1;
            SGR_UNDERLINE:  r.underline = 1'b1;
            SGR_NORMAL_INT:
            begin
                r.bold = 1'b0;
                r.dim  = 1'b0;
            end
            [SGR_FG_FIRST:SGR_FG_LAST]:
                r.colour = COLOUR_ANSI_BASE + {1'b0, 3'(code - SGR_FG_FIRST)};
            SGR_FG_BASE:    r.colour = {3'b000, err};
            [SGR_BRIGHT_FIRST:SGR_BRIGHT_LAST]:
            begin
                r.colour = COLOUR_ANSI_BASE + {1'b0, 3'(code - SGR_BRIGHT_FIRST)};
                r.bold   = 1'b1;
            end
            default:        r = a;
        endcase
        return r;
    endfunction

endpackage

>>> sv/ansi_sgr_text_attribute_parser.sv
// ----------------------------------------------------------------------------
// ANSI SGR text attribute parser
// Turns log-line bytes into glyph requests with column and attributes.
//
// Input channel: data_byte, line_start, error_line with in_valid / in_stall.
// Output channel: one glyph request per printable byte, tab or complete
// UTF-8 sequence, with out_valid / out_stall. Escape sequences, control
// bytes and bytes past max_columns produce nothing.
// Configuration: cfg_we writes cfg_wdata into max_columns; write only
// while no byte is in flight.
// Each byte waits in the input register, is decoded combinationally by the
// core, and its glyph is loaded into the result register when it is taken.
// Throughput: one byte per cycle while the result register is free, as the
// core updates its state for each byte taken.
// Reset: parser returns to text mode, attributes clear, colour default,
// max_columns 80, no request held.
// When the receiver stalls, the result register holds its glyph and the
// input register holds one byte; in_stall rises once both are full.
// ----------------------------------------------------------------------------
module ansi_sgr_text_attribute_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        line_start,
    input  logic        error_line,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] glyph_bytes,
    output logic [2:0]  glyph_length,
    output logic [9:0]  column,
    output logic        bold_on,
    output logic        dim_on,
    output logic        underline_on,
    output logic [3:0]  colour_select
);
    import asgr_pkg::*;

    logic [9:0] max_columns_reg;
    item_t      item_in;
    item_t      item;
    logic       item_valid;
    logic       free;
    logic       fire;
    logic       res_valid;
    glyph_t     res;
    glyph_t     glyph;

    assign item_in.data       = data_byte;
    assign item_in.line_start = line_start;
    assign item_in.error_line = error_line;
    assign fire               = item_valid && free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_columns_reg <= COL_RESET;
        end
        else if (cfg_we)
        begin
            max_columns_reg <= cfg_wdata;
        end
    end

    asgr_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item_in  (item_in),
        .advance  (fire),
        .valid    (item_valid),
        .item     (item)
    );

    asgr_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .max_columns (max_columns_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    asgr_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .glyph     (glyph)
    );

    assign glyph_bytes   = glyph.bytes;
    assign glyph_length  = glyph.length;
    assign column        = glyph.column;
    assign bold_on       = glyph.attr.bold;
    assign dim_on        = glyph.attr.dim;
    assign underline_on  = glyph.attr.underline;
    assign colour_select = glyph.attr.colour;

endmodule

>>> sv/asgr_in_stage.sv
// ----------------------------------------------------------------------------
// ANSI SGR parser input register
// Holds one byte request until the core takes it.
// ----------------------------------------------------------------------------
module asgr_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  asgr_pkg::item_t item_in,
    input  logic            advance,
    output logic            valid,
    output asgr_pkg::item_t item
);
    import asgr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);
    assign valid      = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

endmodule

>>> sv/asgr_core.sv
// ----------------------------------------------------------------------------
// ANSI SGR parser core
// Parser state, SGR parameter collection, UTF-8 assembly and glyph output.
// ----------------------------------------------------------------------------
module asgr_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  asgr_pkg::item_t  item,
    input  logic [9:0]       max_columns,
    output logic             res_valid,
    output asgr_pkg::glyph_t res
);
    import asgr_pkg::*;

    typedef struct packed {
        mode_t                mode;
        logic [1:0]           utf_rem;
        logic [31:0]          gbuf;
        logic [2:0]           gcnt;
        logic [9:0]           col;
        attr_t                attr;
        logic                 base_err;
        logic [9:0]           pval;
        logic                 ppres;
        logic [PCOUNT_W-1:0]  pcount;
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    state_t      cur;
    logic [13:0] digit_sum;
    logic [31:0] lane;
    logic        text;
    logic        push_ok;

    always_comb
    begin
        cur = state_reg;
        if (item.line_start)
        begin
            cur.mode     = MODE_NORMAL;
            cur.utf_rem  = 2'd0;
            cur.gbuf     = 32'h0;
            cur.gcnt     = 3'd0;
            cur.col      = 10'd0;
            cur.attr     = plain_line_attr(item.error_line);
            cur.base_err = item.error_line;
            cur.pval     = 10'd0;
            cur.ppres    = 1'b0;
            cur.pcount   = '0;
        end

        state_next = cur;
        res_valid  = 1'b0;
        res.bytes  = {24'h0, item.data};
        res.length = 3'd1;
        res.column = cur.col;
        res.attr   = cur.attr;

        digit_sum = 14'(cur.pval) * 14'd10 + 14'(item.data[3:0]);
        lane      = 32'(item.data) << {cur.gcnt[1:0], 3'b000};
        push_ok   = cur.pcount < PCOUNT_W'(MAX_PARAMS);
        text      = 1'b0;

        if (cur.col < max_columns)
        begin
            if (cur.utf_rem != 2'd0)
            begin
                state_next.gbuf    = cur.gbuf | lane;
                state_next.gcnt    = cur.gcnt + 3'd1;
                state_next.utf_rem = cur.utf_rem - 2'd1;
                if (cur.utf_rem == 2'd1)
                begin
                    res_valid       = 1'b1;
                    res.bytes       = cur.gbuf | lane;
                    res.length      = cur.gcnt + 3'd1;
                    state_next.gbuf = 32'h0;
                    state_next.gcnt = 3'd0;
                    state_next.col  = cur.col + 10'd1;
                end
            end
            else
            begin
                unique case (cur.mode)
                    MODE_SGR:
                    begin
                        if (item.data < FINAL_MIN)
                        begin
                            if (item.data >= DIGIT_ZERO && item.data <= DIGIT_NINE)
                            begin
                                state_next.pval  = (digit_sum > 14'(PARAM_SAT))
                                                   ? PARAM_SAT : digit_sum[9:0];
                                state_next.ppres = 1'b1;
                            end
                            else if (item.data == SEMI_BYTE)
                            begin
                                if (push_ok)
                                begin
                                    state_next.attr   = apply_code(cur.attr, cur.base_err,
                                                        cur.ppres ? cur.pval : SGR_RESET);
                                    state_next.pcount = cur.pcount + PCOUNT_W'(1);
                                end
                                state_next.pval  = 10'd0;
                                state_next.ppres = 1'b0;
                            end
                        end
                        else
                        begin
                            if (cur.ppres && push_ok)
                            begin
                                state_next.attr = apply_code(cur.attr, cur.base_err,
                                                             cur.pval);
                            end
                            state_next.pval   = 10'd0;
                            state_next.ppres  = 1'b0;
                            state_next.pcount = '0;
                            state_next.mode   = MODE_NORMAL;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (item.data == CSI_BYTE)
                        begin
                            state_next.mode   = MODE_SGR;
                            state_next.pval   = 10'd0;
                            state_next.ppres  = 1'b0;
                            state_next.pcount = '0;
                        end
                        else
                        begin
                            text = 1'b1;
                        end
                    end
                    MODE_NORMAL: text = 1'b1;
                    default:     text = 1'b1;
                endcase

                if (text)
                begin
                    state_next.mode = MODE_NORMAL;
                    if (item.data == ESC_BYTE)
                    begin
                        state_next.mode = MODE_ESC;
                    end
                    else if (item.data[7])
                    begin
                        if (item.data[7:5] == 3'b110)
                        begin
                            state_next.gbuf    = 32'(item.data);
                            state_next.gcnt    = 3'd1;
                            state_next.utf_rem = 2'd1;
                        end
                        else if (item.data[7:4] == 4'b1110)
                        begin
                            state_next.gbuf    = 32'(item.data);
                            state_next.gcnt    = 3'd1;
                            state_next.utf_rem = 2'd2;
                        end
                        else if (item.data[7:3] == 5'b11110)
                        begin
                            state_next.gbuf    = 32'(item.data);
                            state_next.gcnt    = 3'd1;
                            state_next.utf_rem = 2'd3;
                        end
                    end
                    else if (item.data >= SPACE_BYTE || item.data == TAB_BYTE)
                    begin
                        res_valid      = 1'b1;
                        state_next.col = cur.col + 10'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_NORMAL, default: '0};
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    a_utf_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.utf_rem != 2'd0 |-> state_reg.mode == MODE_NORMAL)
        else $error("UTF-8 assembly outside text mode");

    a_pcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pcount <= PCOUNT_W'(MAX_PARAMS))
        else $error("parameter count beyond limit");

    a_utf_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.utf_rem != 2'd0 |->
            (state_reg.gcnt != 3'd0) &&
            (4'(state_reg.gcnt) + 4'(state_reg.utf_rem) <= 4'd4))
        else $error("UTF-8 sequence length out of range");

    a_col_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res_valid |-> res.column < max_columns)
        else $error("glyph beyond column limit");

endmodule

>>> sv/asgr_out_stage.sv
// ----------------------------------------------------------------------------
// ANSI SGR parser result register
// Holds one glyph request until the receiver takes it.
// ----------------------------------------------------------------------------
module asgr_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  asgr_pkg::glyph_t res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output asgr_pkg::glyph_t glyph
);
    import asgr_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    glyph_t glyph_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? res_valid : (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign glyph      = glyph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            glyph_reg <= res;
        end
    end

endmodule
